/* hdl/wpc_pkg.sv */
// Shared types and constants for the window pattern counter.
// Depends on nothing; imported by every module of the block.
package wpc_pkg;

    localparam int DATA_W      = 32;
    localparam int CNT_W       = 32;
    localparam int RANK_W      = 2;
    localparam int POS_W       = 3;
    localparam int OUT_FIELD_W = DATA_W + CNT_W + RANK_W + POS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctl;

endpackage

/* hdl/wpc_table_ram.sv */
// Table memory: one stored window row plus its count per entry.
// Synchronous write, registered read: data appears in the cycle after i_rd_en. Uses wpc_pkg.
module wpc_table_ram
    import wpc_pkg::*;
#(
    parameter  int DEPTH = 3,
    parameter  int WIDTH = 224,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic [WIDTH-1:0]       i_wr_data,
    input  logic                   i_rd_en,
    input  logic [AW-1:0]          i_rd_addr,
    output logic [WIDTH-1:0]       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_q;

endmodule

/* hdl/wpc_window.sv */
// Sliding window of samples with its fill counter and the row comparator.
// Uses wpc_pkg for the sample width and the control struct.
module wpc_window
    import wpc_pkg::*;
#(
    parameter int WINDOW_LEN = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_win_ctl                     i_ctl,
    input  logic [DATA_W-1:0]            i_sample,
    input  logic [WINDOW_LEN*DATA_W-1:0] i_row,
    output logic [WINDOW_LEN*DATA_W-1:0] o_window,
    output logic                         o_lookup,
    output logic                         o_match
);

    localparam int FW = $clog2(WINDOW_LEN + 1);

    logic [DATA_W-1:0] r_win [WINDOW_LEN];
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     n_fill;

    always_comb begin
        n_fill = r_fill;
        if (i_ctl.clear) begin
            n_fill = '0;
        end else if (i_ctl.shift && (r_fill != FW'(WINDOW_LEN))) begin
            n_fill = r_fill + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int k = 0; k < WINDOW_LEN - 1; k++) begin
                r_win[k] <= r_win[k + 1];
            end
            r_win[WINDOW_LEN - 1] <= i_sample;
        end
    end

    // window is full after this beat's shift
    assign o_lookup = (r_fill >= FW'(WINDOW_LEN - 1));

    always_comb begin
        o_match = 1'b1;
        for (int k = 0; k < WINDOW_LEN; k++) begin
            o_window[k*DATA_W +: DATA_W] = r_win[k];
            if (i_row[k*DATA_W +: DATA_W] != r_win[k]) begin
                o_match = 1'b0;
            end
        end
    end

endmodule

/* hdl/window_pattern_counter.sv */
// Counts how often each window of WINDOW_LEN samples occurs, in a table of
// TABLE_ENTRIES rows held in one single-port-read memory; the oldest row is
// replaced when the table is full. Once the window is full, the table memory is
// read (S_RD) and compared (S_CMP) one row at a time through its one read port;
// a matching row is written back with its count incremented, else the window
// is written to a new row. A beat with tlast then dumps every row, oldest
// first, one element per output beat, reading each row (S_DRD) before giving
// its elements (S_DOUT), and clears the table. The memory is not cleared
// after reset; a fill count marks the rows in use.
// Uses wpc_pkg, wpc_window and wpc_table_ram.
module window_pattern_counter
    import wpc_pkg::*;
#(
    parameter int WINDOW_LEN    = 6,
    parameter int TABLE_ENTRIES = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [DATA_W-1:0]      i_s_tdata,   // sample
    input  logic                   i_s_tlast,   // end_of_stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // element_value, occurrences, entry_rank, element_position, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast    // last
);

    localparam int ROW_W = WINDOW_LEN * DATA_W;
    localparam int MEM_W = ROW_W + CNT_W;
    localparam int EW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int UW    = $clog2(TABLE_ENTRIES + 1);
    localparam int RW    = (UW > RANK_W) ? UW : RANK_W;
    localparam int KW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int PW    = (KW > POS_W) ? KW : POS_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_CMP  = 7'b0000100,
        S_INS  = 7'b0001000,
        S_FIN  = 7'b0010000,
        S_DRD  = 7'b0100000,
        S_DOUT = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [EW-1:0] r_ent, n_ent;
    logic [EW-1:0] r_slot, n_slot;
    logic [UW-1:0] r_used, n_used;
    logic          r_eos, n_eos;
    logic [RW-1:0] r_rank, n_rank;
    logic [PW-1:0] r_elem, n_elem;

    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_value, n_out_value;
    logic [CNT_W-1:0]    r_out_count, n_out_count;
    logic [RANK_W-1:0]   r_out_rank, n_out_rank;
    logic [POS_W-1:0]    r_out_pos, n_out_pos;
    logic                r_out_last, n_out_last;

    t_win_ctl          win_ctl;
    logic [ROW_W-1:0]  win_row;
    logic              win_lookup;
    logic              win_match;

    logic              rd_en, wr_en;
    logic [EW-1:0]     rd_addr, wr_addr;
    logic [MEM_W-1:0]  wr_data, rd_data;
    logic [ROW_W-1:0]  rd_row;
    logic [CNT_W-1:0]  rd_count, count_inc;
    logic [EW-1:0]     ent_inc, slot_inc;
    logic              s_accept, out_free, elem_last, rank_last, more_ents;

    wpc_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (win_ctl),
        .i_sample (i_s_tdata),
        .i_row    (rd_row),
        .o_window (win_row),
        .o_lookup (win_lookup),
        .o_match  (win_match)
    );

    wpc_table_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (MEM_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    assign rd_row    = rd_data[ROW_W-1:0];
    assign rd_count  = rd_data[MEM_W-1 -: CNT_W];
    assign count_inc = (rd_count == '1) ? rd_count : rd_count + CNT_W'(1);

    assign ent_inc   = (r_ent == EW'(TABLE_ENTRIES - 1)) ? '0 : r_ent + EW'(1);
    assign slot_inc  = (r_slot == EW'(TABLE_ENTRIES - 1)) ? '0 : r_slot + EW'(1);
    assign more_ents = (UW'(r_ent) + UW'(1)) < r_used;
    assign elem_last = (r_elem == PW'(WINDOW_LEN - 1));
    assign rank_last = (r_rank == RW'(r_used) - RW'(1));

    always_comb begin
        n_state     = r_state;
        n_ent       = r_ent;
        n_slot      = r_slot;
        n_used      = r_used;
        n_eos       = r_eos;
        n_rank      = r_rank;
        n_elem      = r_elem;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_value = r_out_value;
        n_out_count = r_out_count;
        n_out_rank  = r_out_rank;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;
        win_ctl     = '0;
        rd_en       = 1'b0;
        rd_addr     = r_ent;
        wr_en       = 1'b0;
        wr_addr     = r_ent;
        wr_data     = {count_inc, rd_row};

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    win_ctl.shift = 1'b1;
                    n_eos         = i_s_tlast;
                    n_ent         = '0;
                    if (!win_lookup) begin
                        n_state = S_FIN;
                    end else if (r_used == '0) begin
                        n_state = S_INS;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (win_match) begin
                    wr_en   = 1'b1;
                    n_state = S_FIN;
                end else if (more_ents) begin
                    n_ent   = ent_inc;
                    n_state = S_RD;
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                wr_en   = 1'b1;
                wr_addr = r_slot;
                wr_data = {CNT_W'(1), win_row};
                n_slot  = slot_inc;
                if (r_used != UW'(TABLE_ENTRIES)) begin
                    n_used = r_used + UW'(1);
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_eos) begin
                    n_state = S_IDLE;
                end else if (r_used == '0) begin
                    win_ctl.clear = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_rank  = '0;
                    n_ent   = (r_used == UW'(TABLE_ENTRIES)) ? r_slot : '0;
                    n_state = S_DRD;
                end
            end
            S_DRD: begin
                rd_en   = 1'b1;
                n_elem  = '0;
                n_state = S_DOUT;
            end
            S_DOUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = rd_row[r_elem[KW-1:0]*DATA_W +: DATA_W];
                    n_out_count = rd_count;
                    n_out_rank  = r_rank[RANK_W-1:0];
                    n_out_pos   = r_elem[POS_W-1:0];
                    n_out_last  = elem_last && rank_last;
                    if (!elem_last) begin
                        n_elem = r_elem + PW'(1);
                    end else if (rank_last) begin
                        win_ctl.clear = 1'b1;
                        n_used        = '0;
                        n_slot        = '0;
                        n_state       = S_IDLE;
                    end else begin
                        n_rank  = r_rank + RW'(1);
                        n_ent   = ent_inc;
                        n_state = S_DRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent       <= n_ent;
        r_eos       <= n_eos;
        r_rank      <= n_rank;
        r_elem      <= n_elem;
        r_out_value <= n_out_value;
        r_out_count <= n_out_count;
        r_out_rank  <= n_out_rank;
        r_out_pos   <= n_out_pos;
        r_out_last  <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out_pos, r_out_rank, r_out_count, r_out_value};

    a_used_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(TABLE_ENTRIES))
        else $error("table fill count beyond table depth");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("table read and write in one cycle");

    a_dump_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DOUT && out_free && elem_last && rank_last)
        |=> (r_state == S_IDLE && r_used == '0 && r_slot == '0))
        else $error("table not cleared after final dump beat");

endmodule
